[rtl/core/spc_pkg.sv]
// Shared types and constants of the slice pixel compositor.
package spc_pkg;

  // Pixel and configuration port widths.
  localparam int unsigned PIXEL_W     = 32;
  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned RECT_W      = 12;
  localparam int unsigned PCT_W       = 7;
  localparam int unsigned PROD_W      = CHAN_W + PCT_W;

  // Blend arithmetic constants.
  localparam logic [PCT_W-1:0]   PCT_FULL     = 7'd100;
  localparam logic [CHAN_W-1:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [PIXEL_W-1:0] RED_OPAQUE   = 32'hFFFF_0000;

  // Division by 100 as a multiply by 2^21/100 rounded up and a right shift.
  // Exact for every product of an 8-bit channel and a percent up to 100.
  localparam logic [PROD_W-1:0]  RECIP_100    = 15'd20972;
  localparam int unsigned        RECIP_SHIFT  = 21;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLEND_PERCENT    = 3'd0,
    REG_OVERLAY_MODE     = 3'd1,
    REG_CROSSHAIR_ENABLE = 3'd2,
    REG_CROSSHAIR_COLUMN = 3'd3,
    REG_CROSSHAIR_ROW    = 3'd4,
    REG_RECT_LEFT        = 3'd5,
    REG_RECT_TOP         = 3'd6,
    REG_RECT_WIDTH       = 3'd7
  } spc_reg_e;

  // Configuration register set.
  typedef struct packed {
    logic [PCT_W-1:0]             blend_percent;
    logic                         overlay_mode;
    logic                         crosshair_enable;
    logic signed [CFG_DATA_W-1:0] crosshair_column;
    logic signed [CFG_DATA_W-1:0] crosshair_row;
    logic [RECT_W-1:0]            rect_left;
    logic [RECT_W-1:0]            rect_top;
    logic [CFG_DATA_W-1:0]        rect_width;
  } spc_cfg_t;

  localparam spc_cfg_t CFG_RESET = '{
    blend_percent:    PCT_FULL,
    overlay_mode:     1'b0,
    crosshair_enable: 1'b0,
    crosshair_column: 13'h1FFF,
    crosshair_row:    13'h1FFF,
    rect_left:        12'd0,
    rect_top:         12'd0,
    rect_width:       13'd1
  };

endpackage

[rtl/core/spc_pix_if.sv]
// Valid/ready channel interfaces for pixel beats into and out of the compositor.
interface spc_pix_in_if import spc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] old_pixel;
  logic [PIXEL_W-1:0] layer_sample;

  modport source (output valid, output old_pixel, output layer_sample, input ready);
  modport sink   (input valid, input old_pixel, input layer_sample, output ready);
endinterface

interface spc_pix_out_if import spc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] new_pixel;
  logic               pixel_changed;

  modport source (output valid, output new_pixel, output pixel_changed, input ready);
  modport sink   (input valid, input new_pixel, input pixel_changed, output ready);
endinterface

[rtl/core/slice_pixel_compositor.sv]
// Top level of the slice pixel compositor.
// The compositor takes one pixel beat per clock (old framebuffer pixel and layer sample)
// and returns one result beat per input beat, in order. Throughput is one pixel per cycle
// while the output does not stall; a beat passes through the input register, the channel
// product register and the result register of the blend path, and its result is offered
// from the result register.
// Backpressure on the output stalls the pipeline stage by stage, and a new beat is taken
// whenever the input register is free or moving on. Column and row counters step on every
// accepted beat; a write to rect_left or rect_top restarts them at the rectangle origin.
// Users write configuration only while no beat is in flight; the block does not enforce it.
module slice_pixel_compositor import spc_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  spc_pix_in_if.sink            pix_in_i,
  spc_pix_out_if.source         pix_out_o
);

  spc_cfg_t cfg;
  logic     accept;
  logic     hit;

  assign accept = pix_in_i.valid && pix_in_i.ready;

  // Configuration registers.
  spc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Screen position tracking and crosshair detection.
  spc_walker #(
    .COORD_BITS (COORD_BITS)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .hit_o       (hit)
  );

  // Blend datapath.
  spc_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .hit_i   (hit),
    .pix_in  (pix_in_i),
    .pix_out (pix_out_o)
  );

endmodule

[rtl/core/spc_cfg_regs.sv]
// Configuration register file of the compositor, written through a plain write port.
module spc_cfg_regs import spc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output spc_cfg_t              cfg_o
);

  spc_cfg_t cfg_d, cfg_q;

  // Decode the register index and update the addressed field.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BLEND_PERCENT:    cfg_d.blend_percent    = cfg_wdata_i[PCT_W-1:0];
        REG_OVERLAY_MODE:     cfg_d.overlay_mode     = cfg_wdata_i[0];
        REG_CROSSHAIR_ENABLE: cfg_d.crosshair_enable = cfg_wdata_i[0];
        REG_CROSSHAIR_COLUMN: cfg_d.crosshair_column = cfg_wdata_i;
        REG_CROSSHAIR_ROW:    cfg_d.crosshair_row    = cfg_wdata_i;
        REG_RECT_LEFT:        cfg_d.rect_left        = cfg_wdata_i[RECT_W-1:0];
        REG_RECT_TOP:         cfg_d.rect_top         = cfg_wdata_i[RECT_W-1:0];
        REG_RECT_WIDTH:       cfg_d.rect_width       = cfg_wdata_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/spc_walker.sv]
// Column and row counters that walk the rectangle and detect crosshair hits.
module spc_walker import spc_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  spc_cfg_t              cfg_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  accept_i,
  output logic                  hit_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned XW = CW + RECT_W;
  localparam int unsigned EW = CW + CFG_DATA_W + 1;

  logic [CW-1:0] col_d, col_q;
  logic [CW-1:0] row_d, row_q;
  logic [XW-1:0] left_ext, top_ext, wleft_ext;
  logic [CW-1:0] left_c, top_c, wdata_c;
  logic [CW-1:0] offset;
  logic [EW-1:0] offset_inc, width_ext;
  logic          line_end;
  logic          row_hit, col_hit;

  // Rectangle origin and write data reduced to the counter width.
  assign left_ext  = {{CW{1'b0}}, cfg_i.rect_left};
  assign top_ext   = {{CW{1'b0}}, cfg_i.rect_top};
  assign wleft_ext = {{CW{1'b0}}, cfg_wdata_i[RECT_W-1:0]};
  assign left_c    = left_ext[CW-1:0];
  assign top_c     = top_ext[CW-1:0];
  assign wdata_c   = wleft_ext[CW-1:0];

  // A line ends once the offset from the left edge reaches the width minus one.
  assign offset     = col_q - left_c;
  assign offset_inc = {{(CFG_DATA_W + 1){1'b0}}, offset} + {{(EW - 1){1'b0}}, 1'b1};
  assign width_ext  = {{(CW + 1){1'b0}}, cfg_i.rect_width};
  assign line_end   = offset_inc >= width_ext;

  // Crosshair match against the current position; a negative coordinate is off.
  assign row_hit = !cfg_i.crosshair_row[CFG_DATA_W-1] &&
                   ({{RECT_W{1'b0}}, row_q} ==
                    {{CW{1'b0}}, cfg_i.crosshair_row[RECT_W-1:0]});
  assign col_hit = !cfg_i.crosshair_column[CFG_DATA_W-1] &&
                   ({{RECT_W{1'b0}}, col_q} ==
                    {{CW{1'b0}}, cfg_i.crosshair_column[RECT_W-1:0]});
  assign hit_o   = cfg_i.crosshair_enable && (row_hit || col_hit);

  // Next position: restart on an origin write, otherwise step on each beat.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_we_i && (cfg_idx_i == REG_RECT_LEFT)) begin
      col_d = wdata_c;
      row_d = top_c;
    end else if (cfg_we_i && (cfg_idx_i == REG_RECT_TOP)) begin
      col_d = left_c;
      row_d = wdata_c;
    end else if (accept_i) begin
      if (line_end) begin
        col_d = left_c;
        row_d = row_q + {{(CW - 1){1'b0}}, 1'b1};
      end else begin
        col_d = col_q + {{(CW - 1){1'b0}}, 1'b1};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

[rtl/core/spc_blend.sv]
// Three-register blend datapath: input register, product register, result register.
module spc_blend import spc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  spc_cfg_t cfg_i,
  input  logic     hit_i,
  spc_pix_in_if.sink    pix_in,
  spc_pix_out_if.source pix_out
);

  localparam int unsigned NCH   = 3;
  localparam int unsigned QW    = 2 * PROD_W;

  // Stage enables and valid flags.
  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  // Input register.
  logic [PIXEL_W-1:0] old1_q, samp1_q;
  logic               hit1_q;

  // Product register.
  logic [NCH-1:0][PROD_W-1:0] prod_old_d, prod_new_d, prod_old_q, prod_new_q;
  logic [PIXEL_W-1:0]         pass_d, pass_q;
  logic                       use_blend_d, use_blend_q;
  logic                       changed_d, changed2_q;

  // Result register.
  logic [PIXEL_W-1:0] res_d, res_q;
  logic               changed3_q;

  logic [PCT_W-1:0]           pct, inv_pct;
  logic                       alpha_set;
  logic [NCH-1:0][QW-1:0]     q_old_full, q_new_full;
  logic [NCH-1:0][CHAN_W-1:0] chan_sum;

  // Pipeline flow: a stage loads when it is empty or its content moves on.
  assign en3          = !v3_q || pix_out.ready;
  assign en2          = !v2_q || en3;
  assign en1          = !v1_q || en2;
  assign pix_in.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= pix_in.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Capture the beat together with its crosshair decision.
  always_ff @(posedge clk_i) begin
    if (en1) begin
      old1_q  <= pix_in.old_pixel;
      samp1_q <= pix_in.layer_sample;
      hit1_q  <= hit_i;
    end
  end

  // Clamp opacity, form channel products and pick the pass-through value.
  assign pct       = (cfg_i.blend_percent > PCT_FULL) ? PCT_FULL : cfg_i.blend_percent;
  assign inv_pct   = PCT_FULL - pct;
  assign alpha_set = samp1_q[PIXEL_W-1 -: CHAN_W] != '0;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      prod_old_d[c] = PROD_W'(old1_q[c*CHAN_W +: CHAN_W]) * PROD_W'(inv_pct);
      prod_new_d[c] = PROD_W'(samp1_q[c*CHAN_W +: CHAN_W]) * PROD_W'(pct);
    end
    if (hit1_q) begin
      pass_d = RED_OPAQUE;
    end else if (!cfg_i.overlay_mode) begin
      pass_d = samp1_q;
    end else begin
      pass_d = old1_q;
    end
    use_blend_d = !hit1_q && cfg_i.overlay_mode && alpha_set;
    changed_d   = hit1_q || !cfg_i.overlay_mode || alpha_set;
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      prod_old_q  <= prod_old_d;
      prod_new_q  <= prod_new_d;
      pass_q      <= pass_d;
      use_blend_q <= use_blend_d;
      changed2_q  <= changed_d;
    end
  end

  // Divide each product by 100, add the two terms and assemble the pixel, or take the pass-through value.
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      q_old_full[c] = QW'(prod_old_q[c]) * QW'(RECIP_100);
      q_new_full[c] = QW'(prod_new_q[c]) * QW'(RECIP_100);
      chan_sum[c]   = q_old_full[c][RECIP_SHIFT +: CHAN_W] +
                      q_new_full[c][RECIP_SHIFT +: CHAN_W];
    end
    if (use_blend_q) begin
      res_d = {ALPHA_OPAQUE, chan_sum[2], chan_sum[1], chan_sum[0]};
    end else begin
      res_d = pass_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      res_q      <= res_d;
      changed3_q <= changed2_q;
    end
  end

  assign pix_out.valid         = v3_q;
  assign pix_out.new_pixel     = res_q;
  assign pix_out.pixel_changed = changed3_q;

endmodule
